FILE: rtl/core/cram_pkg.sv
// Shared widths and constants for the 3x3 Cramer's rule solver.
// No dependencies; compiled first.
package cram_pkg;

	localparam int IN_W      = 16;          // Q8.8 input entries
	localparam int PROD_W    = 2 * IN_W;    // 2x2 minor products
	localparam int COF_W     = PROD_W + 1;  // cofactor differences
	localparam int DET_W     = 49;          // exact determinant
	localparam int MAG_W     = DET_W - 1;   // determinant magnitude
	localparam int X_W       = 32;          // Q16.16 result
	localparam int OUT_FRAC  = 16;          // result fraction bits
	localparam int Q_W       = X_W + 1;     // quotient bits kept
	localparam int DIV_STEPS = Q_W;         // one quotient bit per stage
	localparam int HI_SHIFT  = Q_W - OUT_FRAC;
	localparam int DET_LAT   = 4;           // determinant stages
	localparam int DIV_LAT   = DIV_STEPS + 2;
	localparam int LAT       = DET_LAT + DIV_LAT;

	localparam logic [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};
	localparam logic [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};

endpackage

FILE: rtl/core/cram_if.sv
// Valid/ready channel interfaces for the solver: system in, solution out.
// Depends on cram_pkg.
interface cram_sys_if;
	logic                            valid;
	logic                            ready;
	logic signed [cram_pkg::IN_W-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	logic signed [cram_pkg::IN_W-1:0] r0, r1, r2;

	modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		r0, r1, r2, input ready);
	modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
		r0, r1, r2, output ready);
endinterface

interface cram_sol_if;
	logic                              valid;
	logic                              ready;
	logic signed [cram_pkg::X_W-1:0]   x0, x1, x2;
	logic signed [cram_pkg::DET_W-1:0] det_value;
	logic                              singular;
	logic                              clipped;

	modport source(output valid, x0, x1, x2, det_value, singular, clipped, input ready);
	modport sink(input valid, x0, x1, x2, det_value, singular, clipped, output ready);
endinterface

FILE: rtl/core/cramer_3x3_solver.sv
// Pipeline from accepted system to solution: 4 determinant stages, 1 divider
// prep stage, 33 quotient-bit stages, 1 saturation/output stage.
// Throughput: one system per cycle; the whole pipeline holds while the output
// stage is full and not taken. Reset clears only the stage valid bits.
// Depends on cram_pkg, cram_if, cram_det and cram_div.
module cramer_3x3_solver (
	input  logic            clk,
	input  logic            arst_n,
	cram_sys_if.sink        sys,
	cram_sol_if.source      sol
);
	import cram_pkg::*;

	logic                    adv;
	logic [LAT-1:0]          vld_q;
	logic signed [DET_W-1:0] det_a, det_b0, det_b1, det_b2;
	logic signed [X_W-1:0]   x0_w, x1_w, x2_w;
	logic                    cl0, cl1, cl2;
	logic signed [DET_W-1:0] det_s [DIV_LAT+1];
	logic                    sing;

	// pipeline advances unless a finished transaction waits at the output
	assign adv       = !vld_q[LAT-1] || sol.ready;
	assign sys.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], sys.valid};
		end
	end

	// determinant of A and of A with each column replaced by r
	cram_det u_det_a (.clk, .en(adv),
		.a00(sys.m00), .a01(sys.m01), .a02(sys.m02),
		.a10(sys.m10), .a11(sys.m11), .a12(sys.m12),
		.a20(sys.m20), .a21(sys.m21), .a22(sys.m22), .det(det_a));
	cram_det u_det_b0 (.clk, .en(adv),
		.a00(sys.r0), .a01(sys.m01), .a02(sys.m02),
		.a10(sys.r1), .a11(sys.m11), .a12(sys.m12),
		.a20(sys.r2), .a21(sys.m21), .a22(sys.m22), .det(det_b0));
	cram_det u_det_b1 (.clk, .en(adv),
		.a00(sys.m00), .a01(sys.r0), .a02(sys.m02),
		.a10(sys.m10), .a11(sys.r1), .a12(sys.m12),
		.a20(sys.m20), .a21(sys.r2), .a22(sys.m22), .det(det_b1));
	cram_det u_det_b2 (.clk, .en(adv),
		.a00(sys.m00), .a01(sys.m01), .a02(sys.r0),
		.a10(sys.m10), .a11(sys.m11), .a12(sys.r1),
		.a20(sys.m20), .a21(sys.m21), .a22(sys.r2), .det(det_b2));

	// one divider lane per solution component
	cram_div u_div0 (.clk, .en(adv), .num(det_b0), .den(det_a), .x(x0_w), .clip(cl0));
	cram_div u_div1 (.clk, .en(adv), .num(det_b1), .den(det_a), .x(x1_w), .clip(cl1));
	cram_div u_div2 (.clk, .en(adv), .num(det_b2), .den(det_a), .x(x2_w), .clip(cl2));

	// determinant rides alongside the dividers
	assign det_s[0] = det_a;
	for (genvar k = 0; k < DIV_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (adv) begin
				det_s[k+1] <= det_s[k];
			end
		end
	end

	// singular system forces zero solutions
	assign sing          = det_s[DIV_LAT] == '0;
	assign sol.valid     = vld_q[LAT-1];
	assign sol.det_value = det_s[DIV_LAT];
	assign sol.singular  = sing;
	assign sol.x0        = sing ? '0 : x0_w;
	assign sol.x1        = sing ? '0 : x1_w;
	assign sol.x2        = sing ? '0 : x2_w;
	assign sol.clipped   = !sing && (cl0 || cl1 || cl2);
endmodule

FILE: rtl/core/cram_det.sv
// Four-stage pipelined 3x3 determinant by first-column cofactor expansion.
// Depends on cram_pkg.
module cram_det (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [cram_pkg::IN_W-1:0]  a00, a01, a02,
	input  logic signed [cram_pkg::IN_W-1:0]  a10, a11, a12,
	input  logic signed [cram_pkg::IN_W-1:0]  a20, a21, a22,
	output logic signed [cram_pkg::DET_W-1:0] det
);
	import cram_pkg::*;

	logic signed [PROD_W-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic signed [IN_W-1:0]   a00_s1, a10_s1, a20_s1, a00_s2, a10_s2, a20_s2;
	logic signed [COF_W-1:0]  c0_s2, c1_s2, c2_s2;
	logic signed [DET_W-1:0]  t0_s3, t1_s3, t2_s3, det_s4;

	// 2x2 minor products, then cofactors, then column terms, then the sum
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s1  <= a11 * a22;
			p1_s1  <= a12 * a21;
			p2_s1  <= a01 * a22;
			p3_s1  <= a02 * a21;
			p4_s1  <= a01 * a12;
			p5_s1  <= a02 * a11;
			a00_s1 <= a00;
			a10_s1 <= a10;
			a20_s1 <= a20;

			c0_s2  <= COF_W'(p0_s1) - COF_W'(p1_s1);
			c1_s2  <= COF_W'(p2_s1) - COF_W'(p3_s1);
			c2_s2  <= COF_W'(p4_s1) - COF_W'(p5_s1);
			a00_s2 <= a00_s1;
			a10_s2 <= a10_s1;
			a20_s2 <= a20_s1;

			t0_s3  <= DET_W'(a00_s2) * DET_W'(c0_s2);
			t1_s3  <= DET_W'(a10_s2) * DET_W'(c1_s2);
			t2_s3  <= DET_W'(a20_s2) * DET_W'(c2_s2);

			det_s4 <= t0_s3 - t1_s3 + t2_s3;
		end
	end

	assign det = det_s4;
endmodule

FILE: rtl/core/cram_div.sv
// Pipelined restoring divider: trunc(num * 2^16 / den) saturated to Q16.16,
// one quotient bit per stage. Depends on cram_pkg.
module cram_div (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [cram_pkg::DET_W-1:0] num,
	input  logic signed [cram_pkg::DET_W-1:0] den,
	output logic signed [cram_pkg::X_W-1:0]   x,
	output logic                              clip
);
	import cram_pkg::*;

	logic [DET_W-1:0] un_abs, ud_abs;
	logic [MAG_W-1:0] un, ud;

	logic [MAG_W-1:0] rem_s [DIV_STEPS+1];
	logic [MAG_W-1:0] ud_s  [DIV_STEPS+1];
	logic [Q_W-1:0]   nlo_s [DIV_STEPS+1];
	logic [Q_W-1:0]   quo_s [DIV_STEPS+1];
	logic             neg_s [DIV_STEPS+1];
	logic             ovf_s [DIV_STEPS+1];

	logic [X_W-1:0]   x_q;
	logic             clip_q;

	// magnitudes and sign of the quotient
	assign un_abs = num[DET_W-1] ? DET_W'(0) - DET_W'(num) : DET_W'(num);
	assign ud_abs = den[DET_W-1] ? DET_W'(0) - DET_W'(den) : DET_W'(den);
	assign un     = un_abs[MAG_W-1:0];
	assign ud     = ud_abs[MAG_W-1:0];

	// prep stage: high numerator bits seed the remainder, overflow caught early
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= MAG_W'(un >> HI_SHIFT);
			ovf_s[0] <= MAG_W'(un >> HI_SHIFT) >= ud;
			nlo_s[0] <= {un[HI_SHIFT-1:0], {OUT_FRAC{1'b0}}};
			ud_s[0]  <= ud;
			quo_s[0] <= '0;
			neg_s[0] <= num[DET_W-1] ^ den[DET_W-1];
		end
	end

	// one restoring step per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [MAG_W:0] trial, diff;
		logic           ge;

		assign trial = {rem_s[k], nlo_s[k][Q_W-1]};
		assign diff  = trial - {1'b0, ud_s[k]};
		assign ge    = trial >= {1'b0, ud_s[k]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
				quo_s[k+1] <= {quo_s[k][Q_W-2:0], ge};
				nlo_s[k+1] <= {nlo_s[k][Q_W-2:0], 1'b0};
				ud_s[k+1]  <= ud_s[k];
				neg_s[k+1] <= neg_s[k];
				ovf_s[k+1] <= ovf_s[k];
			end
		end
	end

	// sign and saturation
	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s[DIV_STEPS]) begin
				if (ovf_s[DIV_STEPS] || quo_s[DIV_STEPS] > Q_W'(X_MIN)) begin
					x_q    <= X_MIN;
					clip_q <= 1'b1;
				end else begin
					x_q    <= X_W'(0) - quo_s[DIV_STEPS][X_W-1:0];
					clip_q <= 1'b0;
				end
			end else begin
				if (ovf_s[DIV_STEPS] || quo_s[DIV_STEPS] > Q_W'(X_MAX)) begin
					x_q    <= X_MAX;
					clip_q <= 1'b1;
				end else begin
					x_q    <= quo_s[DIV_STEPS][X_W-1:0];
					clip_q <= 1'b0;
				end
			end
		end
	end

	assign x    = x_q;
	assign clip = clip_q;
endmodule

FILE: rtl/core/cram_chk.sv
// Port-level checks on the solver's output channel, bound to the top level.
// Depends on cram_pkg.
module cram_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              sol_valid,
	input logic                              sol_ready,
	input logic signed [cram_pkg::X_W-1:0]   x0, x1, x2,
	input logic signed [cram_pkg::DET_W-1:0] det_value,
	input logic                              singular,
	input logic                              clipped
);
	import cram_pkg::*;

	// singular flag tracks a zero determinant
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid |-> singular == (det_value == '0))
		else $error("singular flag disagrees with determinant");

	// singular transactions carry zero solutions and no clip
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && singular |-> x0 == '0 && x1 == '0 && x2 == '0 && !clipped)
		else $error("singular transaction has nonzero solution");

	// a clip leaves at least one component at a rail
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && clipped |-> x0 == X_MAX || x0 == X_MIN || x1 == X_MAX
			|| x1 == X_MIN || x2 == X_MAX || x2 == X_MIN)
		else $error("clipped without a saturated component");

	// stalled output holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sol_valid && !sol_ready |=> sol_valid && $stable(x0) && $stable(x1)
			&& $stable(x2) && $stable(det_value))
		else $error("stalled output changed");
endmodule

bind cramer_3x3_solver cram_chk u_cram_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.sol_valid (sol.valid),
	.sol_ready (sol.ready),
	.x0        (sol.x0),
	.x1        (sol.x1),
	.x2        (sol.x2),
	.det_value (sol.det_value),
	.singular  (sol.singular),
	.clipped   (sol.clipped)
);
